FILE: rtl/point_group_line_and_circle_fit_macros.svh
// Assertion macros used by the port-level checker.
`ifndef POINT_GROUP_LINE_AND_CIRCLE_FIT_MACROS_SVH
`define POINT_GROUP_LINE_AND_CIRCLE_FIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PGF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PGF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/pglcf_pkg.sv
// Package with types and constants of the point group line and circle fit.
package pglcf_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned WideW  = 32;
  localparam int unsigned RadW   = 25;
  localparam int unsigned StatW  = 2;

  localparam logic [StatW-1:0] StatOk   = 2'd0;
  localparam logic [StatW-1:0] StatEmpty = 2'd1;
  localparam logic [StatW-1:0] StatVert = 2'd2;
  localparam logic [StatW-1:0] StatSat  = 2'd3;

  typedef enum logic [3:0] {
    StLoad,
    StMean,
    StScan,
    StScanLast,
    StSlope,
    StIcpt,
    StProjNear,
    StProjFar,
    StRoot,
    StOut
  } state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [WideW-1:0]  slope;
    logic signed [WideW-1:0]  intercept;
    logic signed [CoordW-1:0] near_x;
    logic signed [WideW-1:0]  near_y;
    logic signed [CoordW-1:0] far_x;
    logic signed [WideW-1:0]  far_y;
    logic signed [CoordW-1:0] ctr_x;
    logic signed [CoordW-1:0] ctr_y;
    logic [RadW-1:0]          radius;
    logic [StatW-1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

FILE: rtl/pglcf_if.sv
// Valid-ready channel interfaces for input points and fit results.
interface pglcf_in_if;
  logic                valid;
  logic                ready;
  pglcf_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pglcf_out_if;
  logic                 valid;
  logic                 ready;
  pglcf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/pglcf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pglcf_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/pglcf_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
module pglcf_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pglcf_pkg::div_ctl_t  ctl_i,
  input  logic [NumW-1:0]      num_i,
  input  logic [DenW-1:0]      den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o,
  output logic [DenW-1:0]      rem_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    run_d = run_q;
    trial = {rem_q, quo_q[NumW-1]};
    if (ctl_i.start) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DenW'(trial - {1'b0, den_q});
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = DenW'(trial);
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = ctl_i.busy && !run_q && !ctl_i.start;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/pglcf_sqrt.sv
// Bit-pair integer square root, one result bit per cycle.
module pglcf_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [49:0] val_i,
  output logic        busy_o,
  output logic [24:0] root_o
);

  logic [49:0] rem_q, rem_d;
  logic [24:0] root_q, root_d;
  logic [49:0] val_q, val_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [51:0] trial;
  logic [51:0] cand;

  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    trial  = {rem_q, val_q[49:48]};
    cand   = {25'd0, root_q, 2'b01};
    if (start_i) begin
      rem_d  = '0;
      root_d = '0;
      val_d  = val_i;
      cnt_d  = 5'd25;
      run_d  = 1'b1;
    end else if (run_q) begin
      val_d = {val_q[47:0], 2'b00};
      if (trial >= cand) begin
        rem_d  = 50'(trial - cand);
        root_d = {root_q[23:0], 1'b1};
      end else begin
        rem_d  = 50'(trial);
        root_d = {root_q[23:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    val_q  <= val_d;
  end

  assign busy_o = run_q || start_i;
  assign root_o = root_q;

endmodule

FILE: rtl/point_group_line_and_circle_fit.sv
// Top level of the point group line and circle fit.
// Points are written into the point memory as they are accepted, up to MAX_POINTS.
// After its last point, a group passes through two mean divisions, the point scan, a slope
// division (skipped for a vertical line), the intercept step, two projection steps, the
// root and one output step; a waiting result stalls only that step. Reset clears the
// count, sums and state; memory contents need no clearing.
module point_group_line_and_circle_fit #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pglcf_in_if.sink           in_if,
  pglcf_out_if.source        out_if
);

  localparam int unsigned AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);

  pglcf_pkg::state_e st_q, st_d;

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [CntW-1:0]          idx_q, idx_d;
  logic signed [36:0]       sumx_q, sumx_d, sumy_q, sumy_d;
  logic signed [23:0]       mx_q, mx_d, my_q, my_d;
  logic                     msel_q, msel_d;
  logic signed [63:0]       sxy_q, sxy_d, sxx_q, sxx_d;
  logic [48:0]              dmin_q, dmin_d, dmax_q, dmax_d;
  logic [49:0]              rmax_q, rmax_d;
  logic signed [23:0]       nx_q, nx_d, fx_q, fx_d;
  logic signed [31:0]       slope_q, slope_d, icpt_q, icpt_d;
  logic signed [31:0]       ny_q, ny_d, fy_q, fy_d;
  logic                     sat_q, sat_d, vert_q, vert_d;
  logic                     first_q, first_d;
  logic                     rd_v_q;
  logic                     ovalid_q, ovalid_d;
  pglcf_pkg::out_item_t     odata_q, odata_d;

  logic              we;
  logic [AddrW-1:0]  raddr;
  logic [47:0]       rdata;
  logic              accept;

  pglcf_ram #(.Width(48), .Depth(MAX_POINTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i ({in_if.data.point_x, in_if.data.point_y}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pglcf_pkg::div_ctl_t dctl;
  logic [79:0]         dnum;
  logic [63:0]         dden;
  logic                ddone;
  logic [79:0]         dquo;
  logic [63:0]         drem;
  logic                dstarted_q, dstarted_d;

  pglcf_div #(.NumW(80), .DenW(64)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dctl),
    .num_i  (dnum),
    .den_i  (dden),
    .done_o (ddone),
    .quo_o  (dquo),
    .rem_o  (drem)
  );

  logic        sq_start, sq_busy, sq_started_q, sq_started_d;
  logic [24:0] sq_root;

  pglcf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (rmax_q),
    .busy_o  (sq_busy),
    .root_o  (sq_root)
  );

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (st_q == pglcf_pkg::StLoad);
  assign we = accept && (cnt_q < CntW'(MAX_POINTS));
  assign raddr = idx_q[AddrW-1:0];

  logic signed [36:0] msum;
  logic [36:0]        mabs;
  logic signed [24:0] sx, sy, ldx, ldy;
  logic signed [49:0] pdx, pdy, pxx, pyy;
  logic [48:0]        d2;
  logic [49:0]        r2;
  logic signed [63:0] mulv;
  logic signed [64:0] rnd;
  logic signed [64:0] sum65;
  logic [63:0]        anum;
  logic [79:0]        qv;
  logic               qbig;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v, output logic s);
    s = 1'b0;
    if (v > 65'sd2147483647) begin
      s = 1'b1;
      return 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      s = 1'b1;
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

  logic s1;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      pglcf_pkg::StLoad:
        if (accept && in_if.data.last_point) st_d = pglcf_pkg::StMean;
      pglcf_pkg::StMean:
        if (ddone && msel_q) st_d = pglcf_pkg::StScan;
      pglcf_pkg::StScan:
        if (idx_q == cnt_q) st_d = pglcf_pkg::StScanLast;
      pglcf_pkg::StScanLast:
        st_d = pglcf_pkg::StSlope;
      pglcf_pkg::StSlope:
        if (sxx_q == 64'sd0 || ddone) st_d = pglcf_pkg::StIcpt;
      pglcf_pkg::StIcpt:     st_d = pglcf_pkg::StProjNear;
      pglcf_pkg::StProjNear: st_d = pglcf_pkg::StProjFar;
      pglcf_pkg::StProjFar:  st_d = pglcf_pkg::StRoot;
      pglcf_pkg::StRoot:
        if (sq_started_q && !sq_busy) st_d = pglcf_pkg::StOut;
      pglcf_pkg::StOut:
        if (!ovalid_q || out_if.ready) st_d = pglcf_pkg::StLoad;
      default:               st_d = pglcf_pkg::StLoad;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q; idx_d = idx_q; sumx_d = sumx_q; sumy_d = sumy_q;
    mx_d = mx_q; my_d = my_q; msel_d = msel_q; sxy_d = sxy_q; sxx_d = sxx_q;
    dmin_d = dmin_q; dmax_d = dmax_q; rmax_d = rmax_q; nx_d = nx_q; fx_d = fx_q;
    slope_d = slope_q; icpt_d = icpt_q; ny_d = ny_q; fy_d = fy_q;
    sat_d = sat_q; vert_d = vert_q; first_d = first_q;
    ovalid_d = ovalid_q; odata_d = odata_q;
    dstarted_d = dstarted_q; sq_started_d = sq_started_q;
    dctl = '0; dnum = '0; dden = '0; sq_start = 1'b0;
    msum = msel_q ? sumy_q : sumx_q;
    mabs = msum[36] ? 37'(-msum) : 37'(msum);
    sx = 25'(signed'(rdata[47:24]));
    sy = 25'(signed'(rdata[23:0]));
    ldx = sx - 25'(mx_q);
    ldy = sy - 25'(my_q);
    pdx = ldx * ldx; pdy = ldy * ldy;
    pxx = sx * sx; pyy = sy * sy;
    d2 = 49'(pxx) + 49'(pyy);
    r2 = 50'(pdx) + 50'(pdy);
    mulv = '0; rnd = '0; sum65 = '0; s1 = 1'b0;
    anum = sxy_q[63] ? 64'(-sxy_q) : 64'(sxy_q);
    qv = '0; qbig = 1'b0;

    if (out_if.ready && ovalid_q) ovalid_d = 1'b0;

    unique case (st_q) inside
      pglcf_pkg::StLoad: begin
        if (we) begin
          cnt_d = cnt_q + CntW'(1);
          sumx_d = sumx_q + 37'(in_if.data.point_x);
          sumy_d = sumy_q + 37'(in_if.data.point_y);
        end
        msel_d = 1'b0; dstarted_d = 1'b0; sq_started_d = 1'b0;
      end
      pglcf_pkg::StMean: begin
        dctl.busy = 1'b1;
        dnum = 80'(mabs);
        dden = 64'(cnt_q);
        if (!dstarted_q) begin
          dctl.start = 1'b1;
          dstarted_d = 1'b1;
        end else if (ddone) begin
          qv = msum[36] ? -dquo : dquo;
          if (msel_q) my_d = 24'(qv); else mx_d = 24'(qv);
          msel_d = 1'b1;
          dstarted_d = 1'b0;
          if (msel_q) begin
            idx_d = '0; sxy_d = '0; sxx_d = '0; rmax_d = '0; first_d = 1'b1;
          end
        end
      end
      pglcf_pkg::StScan, pglcf_pkg::StScanLast: begin
        if (st_q == pglcf_pkg::StScan) idx_d = idx_q + CntW'(1);
        if (rd_v_q) begin
          sxy_d = sxy_q + 64'(pdx - pdx + ldx * ldy);
          sxx_d = sxx_q + 64'(pdx);
          if (first_q) begin
            dmin_d = d2; dmax_d = d2; nx_d = 24'(sx); fx_d = 24'(sx);
            first_d = 1'b0;
          end else begin
            if (d2 < dmin_q) begin dmin_d = d2; nx_d = 24'(sx); end
            if (d2 > dmax_q) begin dmax_d = d2; fx_d = 24'(sx); end
          end
          if (r2 > rmax_q) rmax_d = r2;
        end
      end
      pglcf_pkg::StSlope: begin
        if (sxx_q == 64'sd0) begin
          slope_d = '0; vert_d = 1'b1; sat_d = 1'b0;
        end else begin
          vert_d = 1'b0;
          dctl.busy = 1'b1;
          dnum = {anum, 16'd0};
          dden = 64'(sxx_q);
          if (!dstarted_q) begin
            dctl.start = 1'b1;
            dstarted_d = 1'b1;
            sat_d = 1'b0;
          end else if (ddone) begin
            qbig = dquo > (sxy_q[63] ? 80'h8000_0000 : 80'h7fff_ffff);
            if (qbig) begin
              sat_d = 1'b1;
              slope_d = sxy_q[63] ? 32'sh80000000 : 32'sh7fffffff;
            end else begin
              slope_d = sxy_q[63] ? 32'(-dquo) : 32'(dquo);
            end
          end
        end
      end
      pglcf_pkg::StIcpt: begin
        mulv = slope_q * 64'(mx_q);
        rnd = (65'(mulv) + 65'sd32768) >>> 16;
        sum65 = 65'(my_q) - rnd;
        icpt_d = sat32(sum65, s1);
        sat_d = sat_q | s1;
      end
      pglcf_pkg::StProjNear, pglcf_pkg::StProjFar: begin
        mulv = slope_q * 64'((st_q == pglcf_pkg::StProjNear) ? nx_q : fx_q);
        rnd = (65'(mulv) + 65'sd32768) >>> 16;
        sum65 = rnd + 65'(icpt_q);
        if (st_q == pglcf_pkg::StProjNear) ny_d = sat32(sum65, s1);
        else fy_d = sat32(sum65, s1);
        sat_d = sat_q | s1;
      end
      pglcf_pkg::StRoot: begin
        if (!sq_started_q) begin
          sq_start = 1'b1;
          sq_started_d = 1'b1;
        end
      end
      pglcf_pkg::StOut: begin
        if (!ovalid_q || out_if.ready) begin
          ovalid_d = 1'b1;
          odata_d.slope = slope_q;
          odata_d.intercept = icpt_q;
          odata_d.near_x = nx_q;
          odata_d.near_y = ny_q;
          odata_d.far_x = fx_q;
          odata_d.far_y = fy_q;
          odata_d.ctr_x = mx_q;
          odata_d.ctr_y = my_q;
          odata_d.radius = sq_root;
          odata_d.status = sat_q ? pglcf_pkg::StatSat :
                           (vert_q ? pglcf_pkg::StatVert : pglcf_pkg::StatOk);
          cnt_d = '0; sumx_d = '0; sumy_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pglcf_pkg::StLoad;
      cnt_q <= '0;
      sumx_q <= '0;
      sumy_q <= '0;
      ovalid_q <= 1'b0;
      rd_v_q <= 1'b0;
      dstarted_q <= 1'b0;
      sq_started_q <= 1'b0;
      msel_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      sumx_q <= sumx_d;
      sumy_q <= sumy_d;
      ovalid_q <= ovalid_d;
      rd_v_q <= (st_q == pglcf_pkg::StScan) && (idx_q < cnt_q);
      dstarted_q <= dstarted_d;
      sq_started_q <= sq_started_d;
      msel_q <= msel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; mx_q <= mx_d; my_q <= my_d; sxy_q <= sxy_d; sxx_q <= sxx_d;
    dmin_q <= dmin_d; dmax_q <= dmax_d; rmax_q <= rmax_d; nx_q <= nx_d;
    fx_q <= fx_d; slope_q <= slope_d; icpt_q <= icpt_d; ny_q <= ny_d;
    fy_q <= fy_d; sat_q <= sat_d; vert_q <= vert_d; first_q <= first_d;
    odata_q <= odata_d;
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data  = odata_q;

endmodule

FILE: rtl/pglcf_checker.sv
// Port-level checker for the point group line and circle fit, with its bind.
`include "point_group_line_and_circle_fit_macros.svh"
module pglcf_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 in_last_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input pglcf_pkg::out_item_t out_data_i
);

  logic last_acc;
  logic stat_empty;

  assign last_acc   = in_valid_i && in_ready_i && in_last_i;
  assign stat_empty = (out_data_i.status == pglcf_pkg::StatEmpty);

  `PGF_ASSERT_IMP(a_valid_known, clk_i, rst_ni, 1'b1, !$isunknown(out_valid_i))
  `PGF_ASSERT_NXT(a_busy_after_last, clk_i, rst_ni, last_acc, !in_ready_i)
  `PGF_ASSERT_IMP(a_status_never_empty, clk_i, rst_ni, out_valid_i, !stat_empty)
  `PGF_ASSERT_NXT(a_out_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

endmodule

bind point_group_line_and_circle_fit pglcf_checker u_pglcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_last_i   (in_if.data.last_point),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);
